[rtl/circular_deque_macros.svh]
`ifndef CIRCULAR_DEQUE_MACROS_SVH
`define CIRCULAR_DEQUE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CDQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/cdq_pkg.sv]
package cdq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int DATA_W        = 32;

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_REAR  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_REAR   = 3'd3;
    localparam logic [2:0] OP_LIST_FWD   = 3'd4;
    localparam logic [2:0] OP_LIST_REV   = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [2:0]               op;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] data;
        logic                     last;
    } rsp_t;

    // Classified command handed from front to back.
    typedef struct packed {
        logic                     is_push;
        logic                     is_pop;
        logic                     is_list;
        logic                     at_front;
        logic signed [DATA_W-1:0] value;
    } cmd_t;

endpackage

[rtl/cdq_ram.sv]
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[rtl/cdq_front.sv]
module cdq_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  cdq_pkg::req_t req,
    output logic          cmd_valid,
    input  logic          cmd_ready,
    output cdq_pkg::cmd_t cmd
);
    import cdq_pkg::*;

    cmd_t       entry_reg [2];
    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, rd_ptr_reg;
    cmd_t       cmd_in;
    logic       op_known;
    logic       push_q, pop_q;

    always_comb
    begin
        cmd_in.is_push  = (req.op == OP_PUSH_FRONT) || (req.op == OP_PUSH_REAR);
        cmd_in.is_pop   = (req.op == OP_POP_FRONT) || (req.op == OP_POP_REAR);
        cmd_in.is_list  = (req.op == OP_LIST_FWD) || (req.op == OP_LIST_REV);
        cmd_in.at_front = (req.op == OP_PUSH_FRONT) || (req.op == OP_POP_FRONT)
                          || (req.op == OP_LIST_FWD);
        cmd_in.value    = req.value;
        op_known        = cmd_in.is_push || cmd_in.is_pop || cmd_in.is_list;
    end

    assign req_ready = (count_reg != 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = entry_reg[rd_ptr_reg];

    // Drop unknown opcodes: they produce no response.
    assign push_q = req_valid && req_ready && op_known;
    assign pop_q  = cmd_valid && cmd_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push_q && !pop_q)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop_q && !push_q)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push_q)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop_q)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_q)
        begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

[rtl/cdq_back.sv]
`include "circular_deque_macros.svh"

module cdq_back #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  cdq_pkg::cmd_t cmd,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output cdq_pkg::rsp_t rsp
);
    import cdq_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_SEND  = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [IW-1:0] head_reg, head_next;
    logic [IW-1:0] tail_reg, tail_next;
    logic          empty_reg, empty_next;
    logic [IW-1:0] rd_addr_reg, rd_addr_next;
    logic [CW-1:0] remain_reg, remain_next;
    logic          fwd_reg, fwd_next;
    logic          out_valid_reg, out_valid_next;
    rsp_t          out_reg, out_next;

    logic              out_free;
    logic              load_out;
    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    logic [DATA_W-1:0] rd_data;
    logic [IW-1:0]     head_inc, head_dec, tail_inc, tail_dec, addr_inc, addr_dec;
    logic              full;
    logic [CW-1:0]     head_w, tail_w, held;

    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + IW'(1);
    assign head_dec = (head_reg == '0) ? LAST_IDX : head_reg - IW'(1);
    assign tail_inc = (tail_reg == LAST_IDX) ? '0 : tail_reg + IW'(1);
    assign tail_dec = (tail_reg == '0) ? LAST_IDX : tail_reg - IW'(1);
    assign addr_inc = (rd_addr_reg == LAST_IDX) ? '0 : rd_addr_reg + IW'(1);
    assign addr_dec = (rd_addr_reg == '0) ? LAST_IDX : rd_addr_reg - IW'(1);

    assign full   = !empty_reg && (tail_inc == head_reg);
    assign head_w = CW'(head_reg);
    assign tail_w = CW'(tail_reg);
    // Elements held, wrapping around the ring.
    assign held   = (tail_reg >= head_reg) ? tail_w - head_w + CW'(1)
                                           : tail_w + CW'(DEPTH) - head_w + CW'(1);

    assign out_free  = !out_valid_reg || rsp_ready;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        empty_next   = empty_reg;
        rd_addr_next = rd_addr_reg;
        remain_next  = remain_reg;
        fwd_next     = fwd_reg;
        out_next     = out_reg;
        load_out     = 1'b0;
        cmd_ready    = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_ready = 1'b1;
                    if (cmd.is_push)
                    begin
                        load_out = 1'b1;
                        if (full)
                        begin
                            out_next = '{status: ST_FULL, data: '0, last: 1'b1};
                        end
                        else
                        begin
                            out_next = '{status: ST_OK, data: '0, last: 1'b1};
                            wr_en    = 1'b1;
                            if (empty_reg)
                            begin
                                head_next  = '0;
                                tail_next  = '0;
                                empty_next = 1'b0;
                                wr_addr    = '0;
                            end
                            else if (cmd.at_front)
                            begin
                                head_next = head_dec;
                                wr_addr   = head_dec;
                            end
                            else
                            begin
                                tail_next = tail_inc;
                                wr_addr   = tail_inc;
                            end
                        end
                    end
                    else if (empty_reg)
                    begin
                        load_out = 1'b1;
                        out_next = '{status: ST_EMPTY, data: '0, last: 1'b1};
                    end
                    else
                    begin
                        rd_addr_next = cmd.at_front ? head_reg : tail_reg;
                        fwd_next     = cmd.at_front;
                        state_next   = S_FETCH;
                        if (cmd.is_list)
                        begin
                            remain_next = held;
                        end
                        else
                        begin
                            remain_next = CW'(1);
                            if (head_reg == tail_reg)
                            begin
                                empty_next = 1'b1;
                                head_next  = '0;
                                tail_next  = '0;
                            end
                            else if (cmd.at_front)
                            begin
                                head_next = head_inc;
                            end
                            else
                            begin
                                tail_next = tail_dec;
                            end
                        end
                    end
                end
            end
            S_FETCH:
            begin
                state_next = S_SEND;
            end
            S_SEND:
            begin
                if (out_free)
                begin
                    load_out = 1'b1;
                    out_next = '{status: ST_OK, data: rd_data,
                                 last: (remain_reg == CW'(1))};
                    if (remain_reg == CW'(1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        remain_next  = remain_reg - CW'(1);
                        rd_addr_next = fwd_reg ? addr_inc : addr_dec;
                        state_next   = S_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = load_out || (out_valid_reg && !rsp_ready);
    end

    cdq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (cmd.value),
        .rd_addr (rd_addr_reg),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            empty_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            empty_reg     <= empty_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg <= rd_addr_next;
        remain_reg  <= remain_next;
        fwd_reg     <= fwd_next;
        out_reg     <= out_next;
    end

    `CDQ_ASSERT_NOW(a_empty_ptrs_zero, clk, rst_n, empty_reg,
        (head_reg == '0) && (tail_reg == '0), "empty deque with nonzero pointers")
    `CDQ_ASSERT_NOW(a_send_addr_stable, clk, rst_n, state_reg == S_SEND,
        $stable(rd_addr_reg), "read address moved while data is pending")
    `CDQ_ASSERT_NEXT(a_fetch_to_send, clk, rst_n, state_reg == S_FETCH,
        (state_reg == S_SEND) && (remain_reg != '0), "fetch not followed by send")

endmodule

[rtl/circular_deque.sv]
// Double-ended queue of DEPTH 32-bit words held in a ring.
// Request channel (req_valid/req_ready/req): op and value; op 0/1 push at
// front/rear, 2/3 pop front/rear, 4/5 list front-to-rear/rear-to-front.
// Unknown opcodes are consumed and produce no response.
// Response channel (rsp_valid/rsp_ready/rsp): status, data, last. Pushes and
// refused operations give one response; pops give one with the removed word;
// listings give one response per held word with last set on the final one.
// A two-entry command queue decouples request intake from execution, so up to
// two requests are taken while the executer is busy or the response is stalled.
// Pushes and refusals are answered from the idle state via the output register;
// pops and listings pass a fetch and a send state per word, set by the registered
// read of the ring memory. Pushes and refusals sustain one transaction per cycle
// while the response is not stalled; a pop or listing holds off further commands.
// A stalled response holds in the output register; execution waits for it.
// Reset empties the deque and drops queued requests; no clearing pass is run.
module circular_deque #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  cdq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output cdq_pkg::rsp_t rsp
);
    import cdq_pkg::*;

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    cdq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    cdq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

[bench/circular_deque_tb.sv]
`timescale 1ns / 100ps

module circular_deque_tb;

    import cdq_pkg::*;

    localparam int DEPTH          = DEPTH_DEFAULT;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int HOLD_OFF_LEN   = 120;

    // Opcodes the block consumes without answering.
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    class deque_tracker;
        logic [DATA_W-1:0] ring [DEPTH];
        int unsigned       held = 0;
        int unsigned       front = 0;
        int unsigned       rear = 0;
        rsp_t              pending_results[$];
        int                errors = 0;

        function int unsigned step_fwd(input int unsigned i);
            return (i + 1 == DEPTH) ? 0 : i + 1;
        endfunction

        function int unsigned step_back(input int unsigned i);
            return (i == 0) ? DEPTH - 1 : i - 1;
        endfunction

        function void queue_result(input logic [1:0] status, input logic [DATA_W-1:0] data,
                                   input logic last);
            rsp_t item;
            item.status = status;
            item.data   = data;
            item.last   = last;
            pending_results.push_back(item);
        endfunction

        function void note_request(input req_t item);
            int unsigned idx;
            int unsigned n;
            logic [DATA_W-1:0] word;
            case (item.op)
                OP_PUSH_FRONT, OP_PUSH_REAR:
                begin
                    if (held == DEPTH)
                    begin
                        queue_result(ST_FULL, '0, 1'b1);
                    end
                    else
                    begin
                        if (held == 0)
                        begin
                            front = 0;
                            rear  = 0;
                            idx   = 0;
                        end
                        else if (item.op == OP_PUSH_FRONT)
                        begin
                            front = step_back(front);
                            idx   = front;
                        end
                        else
                        begin
                            rear = step_fwd(rear);
                            idx  = rear;
                        end
                        ring[idx] = item.value;
                        held++;
                        queue_result(ST_OK, '0, 1'b1);
                    end
                end
                OP_POP_FRONT, OP_POP_REAR:
                begin
                    if (held == 0)
                    begin
                        queue_result(ST_EMPTY, '0, 1'b1);
                    end
                    else
                    begin
                        idx  = (item.op == OP_POP_FRONT) ? front : rear;
                        word = ring[idx];
                        held--;
                        if (held == 0)
                        begin
                            front = 0;
                            rear  = 0;
                        end
                        else if (item.op == OP_POP_FRONT)
                        begin
                            front = step_fwd(front);
                        end
                        else
                        begin
                            rear = step_back(rear);
                        end
                        queue_result(ST_OK, word, 1'b1);
                    end
                end
                OP_LIST_FWD, OP_LIST_REV:
                begin
                    if (held == 0)
                    begin
                        queue_result(ST_EMPTY, '0, 1'b1);
                    end
                    else
                    begin
                        idx = (item.op == OP_LIST_FWD) ? front : rear;
                        for (n = 0; n < held; n++)
                        begin
                            queue_result(ST_OK, ring[idx], n + 1 == held);
                            idx = (item.op == OP_LIST_FWD) ? step_fwd(idx) : step_back(idx);
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(input rsp_t got);
            rsp_t want;
            if (pending_results.size() == 0)
            begin
                if (errors < 10)
                    $display("unexpected result: status %0d data %h last %0d",
                             got.status, got.data, got.last);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.data !== want.data
                        || got.last !== want.last)
                begin
                    if (errors < 10)
                        $display({"mismatch: expected status %0d data %h last %0d, ",
                                  "got status %0d data %h last %0d"},
                                 want.status, want.data, want.last,
                                 got.status, got.data, got.last);
                    errors++;
                end
            end
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction
    endclass

    logic  clk;
    logic  rst_n;
    logic  req_valid;
    logic  req_ready;
    req_t  req;
    logic  rsp_valid;
    logic  rsp_ready;
    rsp_t  rsp;

    int    req_idle_pct;
    int    rsp_stall_pct;
    int    hold_off_left;

    deque_tracker tracker = new;

    circular_deque #(
        .DEPTH(DEPTH)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_request(input req_t item);
        while ($urandom_range(99) < req_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        tracker.note_request(item);
    endtask

    task automatic send_op(input logic [2:0] op, input logic [DATA_W-1:0] value);
        req_t item;
        item.op    = op;
        item.value = value;
        send_request(item);
    endtask

    function automatic req_t random_request(input int push_pct, input int pop_pct,
                                            input int list_pct);
        req_t item;
        int   roll;
        roll = $urandom_range(99);
        if (roll < push_pct)
            item.op = $urandom_range(1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
        else if (roll < push_pct + pop_pct)
            item.op = $urandom_range(1) ? OP_POP_REAR : OP_POP_FRONT;
        else if (roll < push_pct + pop_pct + list_pct)
            item.op = $urandom_range(1) ? OP_LIST_REV : OP_LIST_FWD;
        else
            item.op = $urandom_range(1) ? OP_SPARE_B : OP_SPARE_A;
        case ($urandom_range(9))
            0:       item.value = 32'h8000_0000;
            1:       item.value = 32'h7fff_ffff;
            default: item.value = $urandom;
        endcase
        return item;
    endfunction

    // Alternate fill, drain and mixed stretches so the store hits full and empty often.
    task automatic run_random(input int n_items);
        int k;
        for (k = 0; k < n_items; k++)
        begin
            case ((k / 24) % 3)
                0:       send_request(random_request(85, 8, 5));
                1:       send_request(random_request(15, 72, 11));
                default: send_request(random_request(45, 40, 13));
            endcase
        end
    endtask

    // Response side: random stalls, or a counted hold-off when requested.
    initial
    begin
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_left > 0)
            begin
                rsp_ready <= 1'b0;
                hold_off_left--;
            end
            else
                rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            tracker.check_result(rsp);
    end

    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet = 0;
            else
            begin
                quiet++;
                if (quiet >= WATCHDOG_LIMIT)
                begin
                    $display("TB_ERROR");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        int k;
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req           = '0;
        req_idle_pct  = 28;
        rsp_stall_pct = 78;
        hold_off_left = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Refusals on an empty store and ignored opcodes.
        send_op(OP_POP_FRONT, '0);
        send_op(OP_POP_REAR, '0);
        send_op(OP_LIST_FWD, '0);
        send_op(OP_LIST_REV, '0);
        send_op(OP_SPARE_A, 32'hffff_ffff);
        send_op(OP_SPARE_B, '0);
        // Single element in and out: store goes back to empty.
        send_op(OP_PUSH_FRONT, 32'h8000_0000);
        send_op(OP_POP_REAR, '0);
        // Fill from both ends, wrapping the front below index zero.
        for (k = 0; k < DEPTH; k++)
        begin
            case (k)
                0:       send_op(OP_PUSH_FRONT, 32'h7fff_ffff);
                1:       send_op(OP_PUSH_REAR, 32'hffff_ffff);
                2:       send_op(OP_PUSH_FRONT, 32'h0000_0000);
                3:       send_op(OP_PUSH_REAR, 32'h8000_0000);
                default: send_op((k % 2) ? OP_PUSH_REAR : OP_PUSH_FRONT, $urandom);
            endcase
        end
        send_op(OP_PUSH_REAR, 32'h1234_5678);
        send_op(OP_LIST_FWD, '0);
        send_op(OP_LIST_REV, '0);
        send_op(OP_POP_FRONT, '0);
        send_op(OP_POP_REAR, '0);

        run_random(115);

        req_idle_pct  = 78;
        rsp_stall_pct = 28;
        run_random(115);

        req_idle_pct  = 0;
        rsp_stall_pct = 0;
        // Back up the response path so the block stalls its input.
        hold_off_left = HOLD_OFF_LEN;
        run_random(115);

        req_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
